// File: src/mbfl_pkg.sv
// ----------------------------------------------------------------------------
// mbfl_pkg
// Shared types and constants of the memory bit-flip fail logger.
// ----------------------------------------------------------------------------
package mbfl_pkg;

    localparam int MAX_RECORDS = 256;
    localparam int WORD_BITS   = 64;

    localparam int DATA_W = 64;
    localparam int ADDR_W = 32;
    localparam int SLOT_W = 8;
    localparam int BIT_W  = 6;
    localparam int CNT_W  = $clog2(MAX_RECORDS + 1);

    localparam logic [DATA_W-1:0] WORD_MASK = {DATA_W{1'b1}} >> (DATA_W - WORD_BITS);
    localparam logic [CNT_W-1:0]  CNT_CAP   = CNT_W'(MAX_RECORDS);
    localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(MAX_RECORDS - 1);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic done;
        logic last;
        logic out_free;
    } t_sts;

endpackage

// File: src/mbfl_if.sv
// ----------------------------------------------------------------------------
// mbfl_if
// Valid/ready channels for scanned words and fail records.
// ----------------------------------------------------------------------------
interface mbfl_in_if;
    logic                        valid;
    logic                        ready;
    logic                        scan_start;
    logic [mbfl_pkg::ADDR_W-1:0] word_address;
    logic [mbfl_pkg::DATA_W-1:0] read_word;
    logic [mbfl_pkg::DATA_W-1:0] pattern_word;

    modport source (output valid, scan_start, word_address, read_word, pattern_word,
                    input ready);
    modport sink   (input valid, scan_start, word_address, read_word, pattern_word,
                    output ready);
endinterface

interface mbfl_out_if;
    logic                        valid;
    logic                        ready;
    logic [mbfl_pkg::SLOT_W-1:0] fail_slot;
    logic [mbfl_pkg::BIT_W-1:0]  flip_bit;
    logic                        flip_direction;
    logic [mbfl_pkg::ADDR_W-1:0] fail_address;
    logic [mbfl_pkg::DATA_W-1:0] expected_value;
    logic [mbfl_pkg::DATA_W-1:0] observed_value;
    logic                        run_last;

    modport source (output valid, fail_slot, flip_bit, flip_direction, fail_address,
                    expected_value, observed_value, run_last,
                    input ready);
    modport sink   (input valid, fail_slot, flip_bit, flip_direction, fail_address,
                    expected_value, observed_value, run_last,
                    output ready);
endinterface

// File: src/mbfl_ctrl.sv
// ----------------------------------------------------------------------------
// mbfl_ctrl
// Sequencer: loads a word, then steps one fail record per free output slot.
// ----------------------------------------------------------------------------
module mbfl_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  mbfl_pkg::t_sts  i_sts,
    output mbfl_pkg::t_cmd  o_cmd
);

    mbfl_pkg::t_state r_state;
    mbfl_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mbfl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        logic finish;
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        finish     = 1'b0;
        unique case (r_state)
            mbfl_pkg::ST_IDLE: begin
                finish = 1'b1;
            end
            mbfl_pkg::ST_RUN: begin
                o_cmd.emit = !i_sts.done && i_sts.out_free;
                finish     = i_sts.done || (i_sts.out_free && i_sts.last);
            end
            default: begin
                finish = 1'b1;
            end
        endcase
        // no item is taken while reset is held
        if (finish && i_rst_n) begin
            o_in_ready = 1'b1;
            o_cmd.load = i_in_valid;
            n_state    = i_in_valid ? mbfl_pkg::ST_RUN : mbfl_pkg::ST_IDLE;
        end
    end

endmodule

// File: src/mbfl_dp.sv
// ----------------------------------------------------------------------------
// mbfl_dp
// Word registers, remaining-difference mask, record counter, output register.
// ----------------------------------------------------------------------------
module mbfl_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mbfl_pkg::t_cmd              i_cmd,
    output mbfl_pkg::t_sts              o_sts,
    input  logic                        i_scan_start,
    input  logic [mbfl_pkg::ADDR_W-1:0] i_word_address,
    input  logic [mbfl_pkg::DATA_W-1:0] i_read_word,
    input  logic [mbfl_pkg::DATA_W-1:0] i_pattern_word,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [mbfl_pkg::SLOT_W-1:0] o_fail_slot,
    output logic [mbfl_pkg::BIT_W-1:0]  o_flip_bit,
    output logic                        o_flip_direction,
    output logic [mbfl_pkg::ADDR_W-1:0] o_fail_address,
    output logic [mbfl_pkg::DATA_W-1:0] o_expected_value,
    output logic [mbfl_pkg::DATA_W-1:0] o_observed_value,
    output logic                        o_run_last
);

    logic [mbfl_pkg::ADDR_W-1:0] r_addr;
    logic [mbfl_pkg::DATA_W-1:0] r_seen;
    logic [mbfl_pkg::DATA_W-1:0] r_want;
    logic [mbfl_pkg::DATA_W-1:0] r_diff;
    logic [mbfl_pkg::DATA_W-1:0] n_diff;
    logic [mbfl_pkg::CNT_W-1:0]  r_cnt;
    logic [mbfl_pkg::CNT_W-1:0]  n_cnt;
    logic                        r_ovalid;

    logic [mbfl_pkg::DATA_W-1:0] low_bit;
    logic [mbfl_pkg::DATA_W-1:0] diff_rest;
    logic [mbfl_pkg::BIT_W-1:0]  low_idx;
    logic                        cap_hit;
    logic                        rec_last;

    // isolate lowest differing bit
    assign low_bit   = r_diff & (~r_diff + mbfl_pkg::DATA_W'(1));
    assign diff_rest = r_diff & ~low_bit;

    always_comb begin
        low_idx = '0;
        for (int i = 0; i < mbfl_pkg::WORD_BITS; i++) begin
            if (low_bit[i]) begin
                low_idx = low_idx | mbfl_pkg::BIT_W'(i);
            end
        end
    end

    assign cap_hit  = (r_cnt >= mbfl_pkg::CNT_CAP);
    assign rec_last = (diff_rest == '0) || (r_cnt == mbfl_pkg::CNT_LAST);

    assign o_sts.done     = (r_diff == '0) || cap_hit;
    assign o_sts.last     = rec_last;
    assign o_sts.out_free = !r_ovalid || i_out_ready;

    always_comb begin
        n_diff = r_diff;
        n_cnt  = r_cnt;
        if (i_cmd.emit) begin
            n_diff = diff_rest;
            n_cnt  = r_cnt + mbfl_pkg::CNT_W'(1);
        end
        if (i_cmd.load) begin
            n_diff = (i_read_word ^ i_pattern_word) & mbfl_pkg::WORD_MASK;
            if (i_scan_start) begin
                n_cnt = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_diff   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_diff <= n_diff;
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr <= i_word_address;
            r_seen <= i_read_word & mbfl_pkg::WORD_MASK;
            r_want <= i_pattern_word & mbfl_pkg::WORD_MASK;
        end
        if (i_cmd.emit) begin
            o_fail_slot      <= r_cnt[mbfl_pkg::SLOT_W-1:0];
            o_flip_bit       <= low_idx;
            o_flip_direction <= |(r_seen & low_bit);
            o_fail_address   <= r_addr;
            o_expected_value <= r_want;
            o_observed_value <= r_seen;
            o_run_last       <= rec_last;
        end
    end

    assign o_out_valid = r_ovalid;

endmodule

// File: src/memory_bitflip_fail_logger_core.sv
// ----------------------------------------------------------------------------
// memory_bitflip_fail_logger_core
// Compares each scanned word with its pattern and logs one record per flip.
// ----------------------------------------------------------------------------
//  channel  dir  handshake    item
//  i_in     in   valid/ready  scan_start, word_address, read_word, pattern_word
//  o_out    out  valid/ready  fail_slot, flip_bit, flip_direction, fail_address,
//                             expected_value, observed_value, run_last
//
//  A matching word logs nothing; a word with flips logs one record per cycle
//  while o_out is free, out of the lowest-set-bit step on the difference mask.
//  The next word is taken in the cycle the last record is registered.
//  Reset (i_rst_n low, synchronous) clears the state machine, the record count
//  and the output valid. A stalled o_out holds the record and pauses the scan.
// ----------------------------------------------------------------------------
module memory_bitflip_fail_logger_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mbfl_in_if.sink    i_in,
    mbfl_out_if.source o_out
);

    mbfl_pkg::t_cmd cmd;
    mbfl_pkg::t_sts sts;

    mbfl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mbfl_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_scan_start     (i_in.scan_start),
        .i_word_address   (i_in.word_address),
        .i_read_word      (i_in.read_word),
        .i_pattern_word   (i_in.pattern_word),
        .o_out_valid      (o_out.valid),
        .i_out_ready      (o_out.ready),
        .o_fail_slot      (o_out.fail_slot),
        .o_flip_bit       (o_out.flip_bit),
        .o_flip_direction (o_out.flip_direction),
        .o_fail_address   (o_out.fail_address),
        .o_expected_value (o_out.expected_value),
        .o_observed_value (o_out.observed_value),
        .o_run_last       (o_out.run_last)
    );

endmodule

// File: tb/mbfl_fail_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mbfl_fail_checker
// Watches both channels of the fail logger. Every accepted word is run
// through a local model of the per-scan record counter and the bit-by-bit
// compare, and the fail records it should cause are queued. Every accepted
// record is checked field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module mbfl_fail_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    mbfl_in_if   i_word,
    mbfl_out_if  i_rec,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_words_seen,
    output int   o_rec_count
);
    import mbfl_pkg::*;

    typedef struct packed {
        logic [SLOT_W-1:0] fail_slot;
        logic [BIT_W-1:0]  flip_bit;
        logic              flip_direction;
        logic [ADDR_W-1:0] fail_address;
        logic [DATA_W-1:0] expected_value;
        logic [DATA_W-1:0] observed_value;
        logic              run_last;
    } t_fail_rec;

    t_fail_rec expected_fails[$];
    int        scan_records = 0;
    int        fail_count   = 0;
    int        words_seen   = 0;
    int        rec_count    = 0;

    // Queue the records one scanned word should produce.
    function automatic void predict_fails(input logic start, input logic [ADDR_W-1:0] addr,
                                          input logic [DATA_W-1:0] rd,
                                          input logic [DATA_W-1:0] pat);
        logic [DATA_W-1:0] seen;
        logic [DATA_W-1:0] want;
        logic [DATA_W-1:0] diff;
        t_fail_rec         rec;
        logic              have_rec;
        seen     = rd & WORD_MASK;
        want     = pat & WORD_MASK;
        diff     = seen ^ want;
        rec      = '0;
        have_rec = 1'b0;
        if (start) begin
            scan_records = 0;
        end
        if (scan_records > MAX_RECORDS) begin
            scan_records = MAX_RECORDS;
        end
        for (int b = 0; b < WORD_BITS; b++) begin
            if (scan_records >= MAX_RECORDS) begin
                break;
            end
            if (diff[b]) begin
                if (have_rec) begin
                    expected_fails.push_back(rec);
                end
                rec.fail_slot      = SLOT_W'(scan_records);
                rec.flip_bit       = BIT_W'(b);
                rec.flip_direction = seen[b];
                rec.fail_address   = addr;
                rec.expected_value = want;
                rec.observed_value = seen;
                rec.run_last       = 1'b0;
                have_rec           = 1'b1;
                scan_records++;
            end
        end
        if (have_rec) begin
            rec.run_last = 1'b1;
            expected_fails.push_back(rec);
        end
    endfunction

    function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
                                        input logic [DATA_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_record(input t_fail_rec got);
        t_fail_rec want;
        if (expected_fails.size() == 0) begin
            $display("%0t: unexpected record: expected none, got slot %0d bit %0d addr 0x%0h",
                     $time, got.fail_slot, got.flip_bit, got.fail_address);
            fail_count++;
            return;
        end
        want = expected_fails.pop_front();
        check_field("fail_slot",      DATA_W'(want.fail_slot),      DATA_W'(got.fail_slot));
        check_field("flip_bit",       DATA_W'(want.flip_bit),       DATA_W'(got.flip_bit));
        check_field("flip_direction", DATA_W'(want.flip_direction), DATA_W'(got.flip_direction));
        check_field("fail_address",   DATA_W'(want.fail_address),   DATA_W'(got.fail_address));
        check_field("expected_value", want.expected_value,          got.expected_value);
        check_field("observed_value", want.observed_value,          got.observed_value);
        check_field("run_last",       DATA_W'(want.run_last),       DATA_W'(got.run_last));
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // records are registered, so one leaving now never stems from a word taken now
            if (i_rec.valid && i_rec.ready) begin
                check_record({i_rec.fail_slot, i_rec.flip_bit, i_rec.flip_direction,
                              i_rec.fail_address, i_rec.expected_value,
                              i_rec.observed_value, i_rec.run_last});
                rec_count++;
            end
            if (i_word.valid && i_word.ready) begin
                predict_fails(i_word.scan_start, i_word.word_address,
                              i_word.read_word, i_word.pattern_word);
                words_seen++;
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_fails.size();
        o_words_seen <= words_seen;
        o_rec_count  <= rec_count;
    end

endmodule

// File: tb/memory_bitflip_fail_logger_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// memory_bitflip_fail_logger_core_tb
// Drives scanned words into the fail logger: a directed set for matching
// words, single flips at both ends, full-word flips in both directions and
// the record cap hit at and inside a word boundary, then random scans under
// four sender-idle / receiver-stall mixes. Checking is done by the checker.
// ----------------------------------------------------------------------------
module memory_bitflip_fail_logger_core_tb;
    import mbfl_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int PHASE_WORDS    = 75;

    localparam logic [DATA_W-1:0] ALL_ONES = '1;
    localparam logic [DATA_W-1:0] ODD_BITS = 64'h5555_5555_5555_5555;
    localparam logic [DATA_W-1:0] EVN_BITS = 64'hAAAA_AAAA_AAAA_AAAA;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int idle_pct     = 0;
    int stall_pct    = 0;
    int quiet_cycles = 0;
    int fail_count;
    int pending;
    int words_seen;
    int rec_count;

    mbfl_in_if  in_ch ();
    mbfl_out_if out_ch ();

    memory_bitflip_fail_logger_core u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    mbfl_fail_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_word       (in_ch),
        .i_rec        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_words_seen (words_seen),
        .o_rec_count  (rec_count)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d records outstanding", $time, pending);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input logic start, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] rd, input logic [DATA_W-1:0] pat);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.scan_start   <= start;
        in_ch.word_address <= addr;
        in_ch.read_word    <= rd;
        in_ch.pattern_word <= pat;
        @(posedge clk);
        while (!in_ch.ready) begin
            @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
    endtask

    // Half the words clean; some with a few flips, some heavily or fully corrupted.
    task automatic send_scan_word(input logic force_start);
        logic              start;
        logic [DATA_W-1:0] pat;
        logic [DATA_W-1:0] flips;
        int                kind;
        start = force_start || ($urandom_range(39) == 0);
        pat   = {$urandom, $urandom};
        kind  = $urandom_range(99);
        flips = '0;
        if (kind >= 90) begin
            flips = ALL_ONES;
        end else if (kind >= 75) begin
            flips = {$urandom, $urandom};
        end else if (kind >= 50) begin
            repeat ($urandom_range(1, 3)) begin
                flips[$urandom_range(DATA_W - 1)] = 1'b1;
            end
        end
        send_word(start, $urandom, pat ^ flips, pat);
    endtask

    initial begin
        in_ch.valid        = 1'b0;
        in_ch.scan_start   = 1'b0;
        in_ch.word_address = '0;
        in_ch.read_word    = '0;
        in_ch.pattern_word = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // counter runs from reset without a scan start
        send_word(1'b0, 32'h0000_0000, 64'h1, 64'h0);
        send_word(1'b0, 32'hFFFF_FFFF, 64'h0, 64'h8000_0000_0000_0000);
        send_word(1'b1, 32'h0000_0010, 64'h0, 64'h0);
        send_word(1'b0, 32'hFFFF_FFF0, ALL_ONES, ALL_ONES);
        // four full-word flips fill the cap exactly at a word boundary
        send_word(1'b0, 32'h0000_0020, ALL_ONES, 64'h0);
        send_word(1'b0, 32'h0000_0028, 64'h0, ALL_ONES);
        send_word(1'b0, 32'h0000_0030, ODD_BITS, EVN_BITS);
        send_word(1'b0, 32'h0000_0038, EVN_BITS, ODD_BITS);
        send_word(1'b0, 32'h0000_0040, 64'h1, 64'h0);
        // cap reached inside a word
        send_word(1'b1, 32'h8000_0000, 64'h8000_0000_0000_0001, 64'h0);
        send_word(1'b0, 32'h8000_0008, ALL_ONES, 64'h0);
        send_word(1'b0, 32'h8000_0010, 64'h0, ALL_ONES);
        send_word(1'b0, 32'h8000_0018, ALL_ONES, 64'h0);
        send_word(1'b0, 32'h8000_0020, ALL_ONES, 64'h0);
        send_word(1'b0, 32'h8000_0028, ALL_ONES, 64'h0);
        send_word(1'b0, 32'h8000_0030, 64'h0, 64'h8000_0000_0000_0000);
        send_word(1'b1, 32'h7FFF_FFFF, ALL_ONES, 64'h0);
        send_word(1'b1, 32'h1234_5678, ODD_BITS, ODD_BITS);
        send_word(1'b0, 32'hDEAD_BEEF, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 70; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 70; end
                default: begin idle_pct = 6; stall_pct <= 6; end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++) begin
                send_scan_word(n == 0);
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Covered %0d scanned words and %0d fail records in open, sender-idle,",
                 words_seen, rec_count);
        $display("receiver-stall and mixed phases, with the record cap hit at and inside a word.");
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
